// ----- src/prc_pkg.sv -----
// shared types, constants and register codes of the presence report block
// no dependencies
`default_nettype none
package prc_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_SAMPLES = 2'd0,
    REG_STALE_TIMEOUT_MS = 2'd1,
    REG_KEEPALIVE_MS     = 2'd2,
    REG_DISTANCE_STEP_CM = 2'd3
  } cfg_idx_t;

  localparam logic [7:0]  DEBOUNCE_RESET  = 8'd3;
  localparam logic [15:0] STALE_RESET     = 16'd2000;
  localparam logic [31:0] KEEPALIVE_RESET = 32'd60000;
  localparam logic [15:0] STEP_RESET      = 16'd20;

  typedef struct packed {
    logic [7:0]  debounce_samples;
    logic [15:0] stale_timeout_ms;
    logic [31:0] keepalive_ms;
    logic [15:0] distance_step_cm;
  } cfg_t;

  // snapshot handed from the front to the back
  typedef struct packed {
    logic [31:0] stamp_ms;
    logic        any_presence;
    logic        moving_flag;
    logic        still_flag;
    logic        pin_debounced;
    logic        radar_live;
    logic [15:0] moving_cm;
    logic [7:0]  moving_energy;
    logic [15:0] still_cm;
    logic [7:0]  still_energy;
    logic [15:0] detect_cm;
    logic        client_ready;
  } snap_t;

endpackage
`default_nettype wire

// ----- src/prc_if.sv -----
// request channels of the presence report block
// depends on nothing
`default_nettype none
interface prc_in_if;
  logic        valid;
  logic        ready;
  logic        pin_level;
  logic        frame_new;
  logic        frame_presence;
  logic        frame_moving;
  logic        frame_stationary;
  logic [15:0] frame_moving_cm;
  logic [7:0]  frame_moving_energy;
  logic [15:0] frame_still_cm;
  logic [7:0]  frame_still_energy;
  logic [15:0] frame_detect_cm;
  logic [31:0] now_ms;
  logic        client_ready;

  modport source (
    output valid, pin_level, frame_new, frame_presence, frame_moving, frame_stationary,
           frame_moving_cm, frame_moving_energy, frame_still_cm, frame_still_energy,
           frame_detect_cm, now_ms, client_ready,
    input  ready
  );
  modport sink (
    input  valid, pin_level, frame_new, frame_presence, frame_moving, frame_stationary,
           frame_moving_cm, frame_moving_energy, frame_still_cm, frame_still_energy,
           frame_detect_cm, now_ms, client_ready,
    output ready
  );
endinterface

interface prc_out_if;
  logic        valid;
  logic        ready;
  logic        report;
  logic [31:0] stamp_ms;
  logic        any_presence;
  logic        moving_flag;
  logic        still_flag;
  logic [15:0] moving_cm;
  logic [7:0]  moving_energy;
  logic [15:0] still_cm;
  logic [7:0]  still_energy;
  logic [15:0] detect_cm;
  logic        pin_debounced;
  logic        radar_live;

  modport source (
    output valid, report, stamp_ms, any_presence, moving_flag, still_flag, moving_cm,
           moving_energy, still_cm, still_energy, detect_cm, pin_debounced, radar_live,
    input  ready
  );
  modport sink (
    input  valid, report, stamp_ms, any_presence, moving_flag, still_flag, moving_cm,
           moving_energy, still_cm, still_energy, detect_cm, pin_debounced, radar_live,
    output ready
  );
endinterface
`default_nettype wire

// ----- src/presence_report_on_change.sv -----
// path: an accepted request is written into the snapshot queue, then into the output register
// throughput: one request per cycle while the queue is not full; the front and back each take
// one request a cycle and the snapshot queue (QDEPTH entries) plus the output register absorb stalls
// reset: synchronous active-low rst_n clears debounce, the kept frame's time (marking it empty),
// reported state and queue, and loads the register defaults; no clearing pass
`default_nettype none
module presence_report_on_change
  import prc_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  prc_in_if.sink                     in_ch,
  prc_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t  cfg_r;
  logic  push, pop, q_full, q_not_empty;
  snap_t push_data, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_samples <= DEBOUNCE_RESET;
      cfg_r.stale_timeout_ms <= STALE_RESET;
      cfg_r.keepalive_ms     <= KEEPALIVE_RESET;
      cfg_r.distance_step_cm <= STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        REG_DEBOUNCE_SAMPLES: cfg_r.debounce_samples <= cfg_wdata[7:0];
        REG_STALE_TIMEOUT_MS: cfg_r.stale_timeout_ms <= cfg_wdata[15:0];
        REG_KEEPALIVE_MS:     cfg_r.keepalive_ms     <= cfg_wdata[31:0];
        REG_DISTANCE_STEP_CM: cfg_r.distance_step_cm <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  prc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  prc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  prc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .head_valid (q_not_empty),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

// ----- src/prc_front.sv -----
// front end: pin debounce, frame keeping and snapshot build per request
// depends on prc_pkg and prc_in_if
`default_nettype none
module prc_front
  import prc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  prc_in_if.sink      in_ch,
  input  wire cfg_t   cfg,
  input  wire logic   q_full,
  output logic        push,
  output snap_t       push_data
);

  logic        started_r, started_nxt;
  logic        raw_r, raw_nxt;
  logic        stable_r, stable_nxt;
  logic [7:0]  run_r, run_nxt;
  logic [2:0]  kflags_r, kflags_nxt;
  logic [15:0] kmov_cm_r, kmov_cm_nxt;
  logic [7:0]  kmov_en_r, kmov_en_nxt;
  logic [15:0] kstill_cm_r, kstill_cm_nxt;
  logic [7:0]  kstill_en_r, kstill_en_nxt;
  logic [15:0] kdet_cm_r, kdet_cm_nxt;
  logic [31:0] ktime_r, ktime_nxt;
  logic [31:0] age;
  logic        live;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    started_nxt = started_r;
    raw_nxt     = raw_r;
    stable_nxt  = stable_r;
    run_nxt     = run_r;
    if (!started_r) begin
      raw_nxt     = in_ch.pin_level;
      stable_nxt  = in_ch.pin_level;
      run_nxt     = cfg.debounce_samples;
      started_nxt = 1'b1;
    end
    if (in_ch.pin_level != raw_nxt) begin
      raw_nxt = in_ch.pin_level;
      run_nxt = 8'd1;
    end else if (run_nxt < cfg.debounce_samples) begin
      run_nxt = run_nxt + 8'd1;
      if (run_nxt == cfg.debounce_samples) begin
        stable_nxt = raw_nxt;
      end
    end
  end

  always_comb begin
    kflags_nxt    = kflags_r;
    kmov_cm_nxt   = kmov_cm_r;
    kmov_en_nxt   = kmov_en_r;
    kstill_cm_nxt = kstill_cm_r;
    kstill_en_nxt = kstill_en_r;
    kdet_cm_nxt   = kdet_cm_r;
    ktime_nxt     = ktime_r;
    if (in_ch.frame_new) begin
      kflags_nxt    = {in_ch.frame_stationary, in_ch.frame_moving, in_ch.frame_presence};
      kmov_cm_nxt   = in_ch.frame_moving_cm;
      kmov_en_nxt   = in_ch.frame_moving_energy;
      kstill_cm_nxt = in_ch.frame_still_cm;
      kstill_en_nxt = in_ch.frame_still_energy;
      kdet_cm_nxt   = in_ch.frame_detect_cm;
      ktime_nxt     = in_ch.now_ms;
    end
  end

  // time zero marks an empty frame slot; age wraps modulo 2^32
  assign age  = in_ch.now_ms - ktime_nxt;
  assign live = (ktime_nxt != 32'd0) && (age <= {16'd0, cfg.stale_timeout_ms});

  always_comb begin
    push_data.stamp_ms      = in_ch.now_ms;
    push_data.any_presence  = (live && kflags_nxt[0]) || stable_nxt;
    push_data.moving_flag   = live && kflags_nxt[1];
    push_data.still_flag    = live && kflags_nxt[2];
    push_data.pin_debounced = stable_nxt;
    push_data.radar_live    = live;
    push_data.moving_cm     = live ? kmov_cm_nxt : 16'd0;
    push_data.moving_energy = live ? kmov_en_nxt : 8'd0;
    push_data.still_cm      = live ? kstill_cm_nxt : 16'd0;
    push_data.still_energy  = live ? kstill_en_nxt : 8'd0;
    push_data.detect_cm     = live ? kdet_cm_nxt : 16'd0;
    push_data.client_ready  = in_ch.client_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      raw_r     <= 1'b0;
      stable_r  <= 1'b0;
      run_r     <= 8'd0;
      ktime_r   <= 32'd0;
    end else if (push) begin
      started_r <= started_nxt;
      raw_r     <= raw_nxt;
      stable_r  <= stable_nxt;
      run_r     <= run_nxt;
      ktime_r   <= ktime_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      kflags_r    <= kflags_nxt;
      kmov_cm_r   <= kmov_cm_nxt;
      kmov_en_r   <= kmov_en_nxt;
      kstill_cm_r <= kstill_cm_nxt;
      kstill_en_r <= kstill_en_nxt;
      kdet_cm_r   <= kdet_cm_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/prc_queue.sv -----
// short snapshot queue between front and back
// depends on prc_pkg
`default_nettype none
module prc_queue
  import prc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire snap_t push_data,
  input  wire logic  pop,
  output snap_t      head,
  output logic       not_empty,
  output logic       full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  snap_t          mem [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;

  assign head      = mem[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == FULL_CNT);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/prc_back.sv -----
// back end: report decision, last reported state and output register
// depends on prc_pkg and prc_out_if
`default_nettype none
module prc_back
  import prc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire snap_t head,
  input  wire logic  head_valid,
  output logic       pop,
  prc_out_if.source  out_ch
);

  logic        has_rep_r;
  logic [4:0]  rep_flags_r;
  logic [15:0] rep_mov_r, rep_still_r, rep_det_r;
  logic [31:0] rep_time_r;
  logic        out_valid_r;
  logic        out_report_r;
  snap_t       out_snap_r;

  logic [4:0]  flags;
  logic [15:0] d_mov, d_still, d_det;
  logic [31:0] since;
  logic        moved, publish;

  function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  assign pop = head_valid && (!out_valid_r || out_ch.ready);

  assign flags   = {head.radar_live, head.pin_debounced, head.still_flag,
                    head.moving_flag, head.any_presence};
  assign d_mov   = abs_diff(head.moving_cm, rep_mov_r);
  assign d_still = abs_diff(head.still_cm, rep_still_r);
  assign d_det   = abs_diff(head.detect_cm, rep_det_r);
  assign moved   = head.radar_live && ((d_mov >= cfg.distance_step_cm) ||
                   (d_still >= cfg.distance_step_cm) || (d_det >= cfg.distance_step_cm));
  assign since   = head.stamp_ms - rep_time_r;
  assign publish = head.client_ready &&
                   (!has_rep_r || (flags != rep_flags_r) || moved ||
                    (since >= cfg.keepalive_ms));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_rep_r   <= 1'b0;
      rep_flags_r <= 5'd0;
      rep_mov_r   <= 16'd0;
      rep_still_r <= 16'd0;
      rep_det_r   <= 16'd0;
      rep_time_r  <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop && publish) begin
        has_rep_r   <= 1'b1;
        rep_flags_r <= flags;
        rep_mov_r   <= head.moving_cm;
        rep_still_r <= head.still_cm;
        rep_det_r   <= head.detect_cm;
        rep_time_r  <= head.stamp_ms;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_report_r <= publish;
      out_snap_r   <= head;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.report        = out_report_r;
  assign out_ch.stamp_ms      = out_snap_r.stamp_ms;
  assign out_ch.any_presence  = out_snap_r.any_presence;
  assign out_ch.moving_flag   = out_snap_r.moving_flag;
  assign out_ch.still_flag    = out_snap_r.still_flag;
  assign out_ch.moving_cm     = out_snap_r.moving_cm;
  assign out_ch.moving_energy = out_snap_r.moving_energy;
  assign out_ch.still_cm      = out_snap_r.still_cm;
  assign out_ch.still_energy  = out_snap_r.still_energy;
  assign out_ch.detect_cm     = out_snap_r.detect_cm;
  assign out_ch.pin_debounced = out_snap_r.pin_debounced;
  assign out_ch.radar_live    = out_snap_r.radar_live;

endmodule
`default_nettype wire
